// ----- hw/rtl/ehfrp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Unwind frame record parser package
// Shared widths, character codes, error codes and the result beat type.
// -----------------------------------------------------------------------------
package ehfrp_pkg;

   localparam int MAX_LEB_BYTES_DEFAULT = 9;

   // Width of a decoded LEB128 value as presented on the result port.
   localparam int LEB_W = 63;

   localparam logic [7:0] CHAR_Z   = 8'h7a;
   localparam logic [7:0] CHAR_R   = 8'h52;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_AUG   = 3'd1;
   localparam logic [2:0] ERR_LEB_LONG  = 3'd2;
   localparam logic [2:0] ERR_TRUNCATED = 3'd3;
   localparam logic [2:0] ERR_ORDER     = 3'd4;

   localparam logic KIND_CIE = 1'b0;
   localparam logic KIND_FDE = 1'b1;

   typedef struct packed {
      logic                    record_kind;
      logic [31:0]             record_length;
      logic [31:0]             record_id;
      logic [7:0]              cie_version;
      logic [1:0]              aug_flags;
      logic [LEB_W-1:0]        code_align;
      logic signed [LEB_W-1:0] data_align;
      logic [LEB_W-1:0]        return_reg;
      logic [2:0]              parse_error;
   } result_type;

endpackage
`default_nettype wire

// ----- hw/rtl/eh_frame_record_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one section byte per cycle while req_stall is low, set by the single parse stage.
// A record summary is registered and appears on rsp_ in the cycle after its last byte is taken.
// An input beat that closes a record is stalled only while the previous summary
// is still held in the result register and not being taken.
// Reset (synchronous, active high) returns the parser to the first length byte
// of the first record; no clearing pass is needed.
// -----------------------------------------------------------------------------
// Unwind frame section record parser
// Splits a byte stream into length/id records, decodes the CIE header fields
// and reports one summary beat per record.
// -----------------------------------------------------------------------------
module eh_frame_record_parser import ehfrp_pkg::*; #(
   parameter int MAX_LEB_BYTES = MAX_LEB_BYTES_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [7:0]              req_data_byte,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_record_kind,
   output logic [31:0]                  rsp_record_length,
   output logic [31:0]                  rsp_record_id,
   output logic [7:0]                   rsp_cie_version,
   output logic [1:0]                   rsp_aug_flags,
   output logic [LEB_W-1:0]             rsp_code_align,
   output logic signed [LEB_W-1:0]      rsp_data_align,
   output logic [LEB_W-1:0]             rsp_return_reg,
   output logic [2:0]                   rsp_parse_error
);

   localparam int CNT_W = (MAX_LEB_BYTES > 1) ? $clog2(MAX_LEB_BYTES) : 1;
   localparam int SH_W  = 7;

   localparam logic [2:0] PH_LEN  = 3'd0;
   localparam logic [2:0] PH_ID   = 3'd1;
   localparam logic [2:0] PH_VER  = 3'd2;
   localparam logic [2:0] PH_AUG  = 3'd3;
   localparam logic [2:0] PH_CODE = 3'd4;
   localparam logic [2:0] PH_DATA = 3'd5;
   localparam logic [2:0] PH_RET  = 3'd6;
   localparam logic [2:0] PH_SKIP = 3'd7;

   logic [2:0]        phase_ff, phase_in;
   logic [31:0]       bytes_ff, bytes_in;
   logic [31:0]       length_ff, length_in;
   logic [31:0]       id_ff, id_in;
   logic [7:0]        version_ff, version_in;
   logic [1:0]        aug_ff, aug_in;
   logic [LEB_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LEB_W-1:0]  code_ff, code_in;
   logic [LEB_W-1:0]  data_ff, data_in;
   logic [LEB_W-1:0]  ret_ff, ret_in;
   logic [2:0]        err_ff, err_in;
   logic              first_done_ff, first_done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        result_ff, result_in;

   logic              emit;
   logic              accept;
   logic [SH_W-1:0]   shift_lo;
   logic [LEB_W-1:0]  acc_or;
   logic [LEB_W-1:0]  leb_value;
   logic              leb_signed;
   logic              id_done;

   // Bit position of the current LEB128 group and the value once this byte is merged.
   assign shift_lo = SH_W'(count_ff) * SH_W'(7);
   assign acc_or   = acc_ff | (LEB_W'(req_data_byte[6:0]) << shift_lo);
   assign leb_signed = (phase_ff == PH_DATA);
   // The sign of a finished signed value is bit 6 of its last byte.
   assign leb_value = (leb_signed && req_data_byte[6]) ?
                      (acc_or | ({LEB_W{1'b1}} << (shift_lo + SH_W'(7)))) : acc_or;

   always_comb begin
      phase_in      = phase_ff;
      bytes_in      = bytes_ff;
      length_in     = length_ff;
      id_in         = id_ff;
      version_in    = version_ff;
      aug_in        = aug_ff;
      acc_in        = acc_ff;
      count_in      = count_ff;
      code_in       = code_ff;
      data_in       = data_ff;
      ret_in        = ret_ff;
      err_in        = err_ff;
      first_done_in = first_done_ff;
      emit          = 1'b0;
      id_done       = 1'b0;

      if (phase_ff == PH_LEN) begin
         length_in = length_ff | (32'(req_data_byte) << {bytes_ff[1:0], 3'b000});
         if (bytes_ff[1:0] == 2'd3) begin
            bytes_in = '0;
            phase_in = PH_ID;
            emit     = (length_in == 32'd0);
         end else begin
            bytes_in = bytes_ff + 32'd1;
         end
      end else begin
         case (phase_ff)
            PH_ID: begin
               id_in = id_ff | (32'(req_data_byte) << {bytes_ff[1:0], 3'b000});
            end
            PH_VER: begin
               version_in = req_data_byte;
               phase_in   = PH_AUG;
            end
            PH_AUG: begin
               if (req_data_byte == CHAR_NUL) begin
                  phase_in = PH_CODE;
               end else if (req_data_byte == CHAR_Z) begin
                  aug_in = aug_ff | 2'b01;
               end else if (req_data_byte == CHAR_R) begin
                  aug_in = aug_ff | 2'b10;
               end else begin
                  err_in   = (err_ff == ERR_NONE) ? ERR_BAD_AUG : err_ff;
                  phase_in = PH_SKIP;
               end
            end
            PH_CODE, PH_DATA, PH_RET: begin
               if (req_data_byte[7]) begin
                  if (count_ff == CNT_W'(MAX_LEB_BYTES - 1)) begin
                     acc_in   = '0;
                     count_in = '0;
                     err_in   = (err_ff == ERR_NONE) ? ERR_LEB_LONG : err_ff;
                     phase_in = PH_SKIP;
                  end else begin
                     acc_in   = acc_or;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  acc_in   = '0;
                  count_in = '0;
                  case (phase_ff)
                     PH_CODE: begin
                        code_in  = leb_value;
                        phase_in = PH_DATA;
                     end
                     PH_DATA: begin
                        data_in  = leb_value;
                        phase_in = PH_RET;
                     end
                     default: begin
                        ret_in   = leb_value;
                        phase_in = PH_SKIP;
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase

         bytes_in = bytes_ff + 32'd1;

         // The id word is complete: check record order and pick the body parse.
         id_done = (phase_ff == PH_ID) && (bytes_in == 32'd4);
         if (id_done) begin
            if ((id_in == 32'd0) == first_done_ff) begin
               err_in   = (err_ff == ERR_NONE) ? ERR_ORDER : err_ff;
               phase_in = PH_SKIP;
            end else if (id_in == 32'd0) begin
               phase_in = PH_VER;
            end else begin
               phase_in = PH_SKIP;
            end
         end

         emit = (bytes_in == length_ff);
      end

      result_in.record_kind   = (id_in != 32'd0) ? KIND_FDE : KIND_CIE;
      result_in.record_length = length_in;
      result_in.record_id     = id_in;
      result_in.cie_version   = version_in;
      result_in.aug_flags     = aug_in;
      result_in.code_align    = code_in;
      result_in.data_align    = data_in;
      result_in.return_reg    = ret_in;
      if (err_in != ERR_NONE) begin
         result_in.parse_error = err_in;
      end else if (phase_in != PH_SKIP) begin
         result_in.parse_error = ERR_TRUNCATED;
      end else begin
         result_in.parse_error = ERR_NONE;
      end

      // A finished record leaves every per-record field cleared for the next one.
      if (emit) begin
         phase_in      = PH_LEN;
         bytes_in      = '0;
         length_in     = '0;
         id_in         = '0;
         version_in    = '0;
         aug_in        = '0;
         acc_in        = '0;
         count_in      = '0;
         code_in       = '0;
         data_in       = '0;
         ret_in        = '0;
         err_in        = ERR_NONE;
         first_done_in = 1'b1;
      end
   end

   // Only a beat that closes a record needs room in the result register.
   assign req_stall    = emit && rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || (accept && emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN;
         bytes_ff      <= '0;
         length_ff     <= '0;
         id_ff         <= '0;
         version_ff    <= '0;
         aug_ff        <= '0;
         acc_ff        <= '0;
         count_ff      <= '0;
         code_ff       <= '0;
         data_ff       <= '0;
         ret_ff        <= '0;
         err_ff        <= ERR_NONE;
         first_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            bytes_ff      <= bytes_in;
            length_ff     <= length_in;
            id_ff         <= id_in;
            version_ff    <= version_in;
            aug_ff        <= aug_in;
            acc_ff        <= acc_in;
            count_ff      <= count_in;
            code_ff       <= code_in;
            data_ff       <= data_in;
            ret_ff        <= ret_in;
            err_ff        <= err_in;
            first_done_ff <= first_done_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_record_kind   = result_ff.record_kind;
   assign rsp_record_length = result_ff.record_length;
   assign rsp_record_id     = result_ff.record_id;
   assign rsp_cie_version   = result_ff.cie_version;
   assign rsp_aug_flags     = result_ff.aug_flags;
   assign rsp_code_align    = result_ff.code_align;
   assign rsp_data_align    = result_ff.data_align;
   assign rsp_return_reg    = result_ff.return_reg;
   assign rsp_parse_error   = result_ff.parse_error;

endmodule
`default_nettype wire
